// ----- sv/bhm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_pkg: shared types and codes of the bucketed hash map
// Request opcodes, response status codes and the layout of one slot entry.
// ----------------------------------------------------------------------------
package bhm_pkg;

   localparam int KeyWidth   = 32;
   localparam int ValueWidth = 32;

   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic signed [ValueWidth-1:0] MissValue = -32'sd1;

   typedef struct packed {
      logic                         valid;
      logic signed [KeyWidth-1:0]   key;
      logic signed [ValueWidth-1:0] value;
   } entry_type;

endpackage

// ----- sv/bhm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_if: request and response channels of the bucketed hash map
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bhm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] key;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output key, output value, input ready);
   modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface bhm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);
endinterface

// ----- sv/bucketed_hash_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_hash_map: set-associative key-value store
// BUCKETS buckets of WAYS slots; put, get and remove on 32-bit signed keys.
// ----------------------------------------------------------------------------
//  channel   direction  payload                  role
//  req_bus   in         opcode, key, value       one operation
//  rsp_bus   out        status, read_value       one response per request
//
//  One request at a time; a BUCKETS that is not a power of two adds a
//  remainder loop to the indexing. The scan reads one way per cycle from the
//  single read port of the slot memory. Reset starts a clearing pass over all
//  BUCKETS*WAYS slots; no request is taken until it ends. A stalled response
//  holds; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module bucketed_hash_map
   import bhm_pkg::*;
#(
   parameter int BUCKETS = 1024,
   parameter int WAYS    = 4
) (
   input  logic  clock,
   input  logic  reset,
   bhm_req_if.sink   req_bus,
   bhm_rsp_if.source rsp_bus
);

   localparam int SLOTS = BUCKETS * WAYS;
   localparam int AW    = $clog2(SLOTS);
   localparam int BW    = $clog2(BUCKETS);
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCW   = $clog2(WAYS + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]        clr_addr_ff;
   logic [1:0]           op_ff;
   logic signed [31:0]   key_ff;
   logic signed [31:0]   value_ff;
   logic [AW-1:0]        base_ff;
   logic [WCW-1:0]       rd_way_ff;
   logic                 cmp_vld_ff;
   logic [WW-1:0]        cmp_way_ff;
   logic                 hit_ff;
   logic [WW-1:0]        hit_way_ff;
   logic signed [31:0]   hit_value_ff;
   logic                 free_ff;
   logic [WW-1:0]        free_way_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic signed [31:0]   rsp_value_ff;

   logic                 accept;
   logic                 idx_done;
   logic [BW-1:0]        idx_bucket;
   logic                 rd_en;
   entry_type            rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;
   logic                 finish;
   logic                 last_cmp;
   logic [1:0]           done_status;
   logic signed [31:0]   done_value;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rd_en         = (state_ff == S_SCAN) && (rd_way_ff < WCW'(WAYS));
   assign last_cmp      = cmp_vld_ff && (cmp_way_ff == WW'(WAYS - 1));
   assign finish        = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   bhm_index #(
      .BUCKETS (BUCKETS)
   ) u_index (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .key    (req_bus.key),
      .done   (idx_done),
      .bucket (idx_bucket)
   );

   bhm_store #(
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (base_ff + AW'(rd_way_ff)),
      .rd_data (rd_data)
   );

   // resolve the operation from the scan results and pick the write-back
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      done_status = ST_OK;
      done_value  = '0;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else begin
         case (op_ff)
            OP_PUT: begin
               wr_data = '{valid: 1'b1, key: key_ff, value: value_ff};
               if (hit_ff) begin
                  wr_en   = finish;
                  wr_addr = base_ff + AW'(hit_way_ff);
               end else if (free_ff) begin
                  wr_en   = finish;
                  wr_addr = base_ff + AW'(free_way_ff);
               end else begin
                  done_status = ST_FULL;
               end
            end
            OP_GET: begin
               if (hit_ff) begin
                  done_value = hit_value_ff;
               end else begin
                  done_status = ST_MISSING;
                  done_value  = MissValue;
               end
            end
            OP_REMOVE: begin
               if (hit_ff) begin
                  wr_en   = finish;
                  wr_addr = base_ff + AW'(hit_way_ff);
               end else begin
                  done_status = ST_MISSING;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_addr_ff == AW'(SLOTS - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept) state_in = S_HASH;
         S_HASH:  if (idx_done) state_in = S_SCAN;
         S_SCAN:  if (last_cmp) state_in = S_DONE;
         S_DONE:  if (finish) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= rd_en;
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         op_ff    <= req_bus.opcode;
         key_ff   <= req_bus.key;
         value_ff <= req_bus.value;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end
      if (state_ff == S_HASH && idx_done) begin
         base_ff   <= AW'(idx_bucket) * AW'(WAYS);
         rd_way_ff <= '0;
      end
      if (rd_en) begin
         rd_way_ff <= rd_way_ff + 1'b1;
      end
      cmp_way_ff <= WW'(rd_way_ff);

      // compare each way as its entry returns; keep the first free slot
      if (state_ff == S_SCAN && cmp_vld_ff) begin
         if (rd_data.valid && rd_data.key == key_ff) begin
            hit_ff       <= 1'b1;
            hit_way_ff   <= cmp_way_ff;
            hit_value_ff <= rd_data.value;
         end
         if (!rd_data.valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_way_ff <= cmp_way_ff;
         end
      end

      if (finish) begin
         rsp_status_ff <= done_status;
         rsp_value_ff  <= done_value;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_value_ff;

endmodule

// ----- sv/bhm_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_index: bucket index unit
// Reduces a 32-bit key modulo BUCKETS. A power-of-two size registers the low bits;
// any other size runs a remainder loop, four key bits a cycle.
// ----------------------------------------------------------------------------
module bhm_index #(
   parameter int BUCKETS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                key,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] bucket
);

   localparam int  BW        = $clog2(BUCKETS);
   localparam bit  Pow2      = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam int  BitsStep  = 4;
   localparam int  StepsLast = 32 / BitsStep - 1;

   generate
      if (Pow2) begin : g_mask
         logic [BW-1:0] bucket_ff;
         logic          done_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               bucket_ff <= key[BW-1:0];
            end
         end

         assign done   = done_ff;
         assign bucket = bucket_ff;
      end else begin : g_rem
         logic [BW-1:0] rem_ff;
         logic [BW-1:0] rem_in;
         logic [31:0]   key_ff;
         logic [$clog2(StepsLast+1)-1:0] cnt_ff;
         logic          busy_ff;
         logic          done_ff;
         logic          last_step;

         assign last_step = busy_ff && (cnt_ff == ($clog2(StepsLast+1))'(StepsLast));

         // shift in one key bit and reduce, four times
         always_comb begin
            logic [BW:0] t;
            rem_in = rem_ff;
            for (int i = 0; i < BitsStep; i++) begin
               t = {rem_in, key_ff[31-i]};
               if (t >= (BW+1)'(BUCKETS)) begin
                  t = t - (BW+1)'(BUCKETS);
               end
               rem_in = t[BW-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               done_ff <= !start && last_step;
               if (start) begin
                  busy_ff <= 1'b1;
               end else if (last_step) begin
                  busy_ff <= 1'b0;
               end
            end
            if (start) begin
               key_ff <= key;
               rem_ff <= '0;
               cnt_ff <= '0;
            end else if (busy_ff) begin
               key_ff <= key_ff << BitsStep;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end

         assign done   = done_ff;
         assign bucket = rem_ff;
      end
   endgenerate

endmodule

// ----- sv/bhm_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_store: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhm_store
   import bhm_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
